// ----- sv/pbc_pkg.sv -----
// Shared types and constants for the period barrier controller.
package pbc_pkg;

    localparam int NUM_CLIENTS = 64;
    localparam int CLIENT_AW   = $clog2(NUM_CLIENTS);
    localparam int SCAN_W      = $clog2(NUM_CLIENTS + 1);
    localparam int CFG_IDX_W   = 8;

    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_UNREGISTER = 2'd1,
        OP_FINISHED   = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_ALREADY_REG = 3'd1,
        ST_RANGE       = 3'd2,
        ST_NOT_REG     = 3'd3,
        ST_AHEAD       = 3'd4,
        ST_STALE       = 3'd5,
        ST_HALTED      = 3'd6
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_TIME    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALT_PERIOD = 8'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [15:0]        client_num;
        logic signed [31:0] period_id;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic        permission_sent;
        logic [30:0] permission_period;
        logic [31:0] permission_run_time;
        logic [31:0] permission_sequence;
        logic [6:0]  registered_count;
        logic        halted;
    } t_out;

    typedef struct packed {
        logic [6:0]  min_count;
        logic [31:0] barrier_run_time;
        logic [30:0] halt_period;
    } t_cfg;

    typedef struct packed {
        logic        registered;
        logic [31:0] last_period;
    } t_entry;

    typedef struct packed {
        logic                 rd_en;
        logic [CLIENT_AW-1:0] rd_addr;
        logic                 wr_en;
        logic [CLIENT_AW-1:0] wr_addr;
        t_entry               wr_data;
    } t_mem_req;

endpackage

// ----- sv/pbc_mem.sv -----
// Client table: one synchronous RAM with per-entry valid bits cleared at reset.
module pbc_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pbc_pkg::t_mem_req i_req,
    output pbc_pkg::t_entry   o_rd
);
    import pbc_pkg::*;

    t_entry                 r_mem [NUM_CLIENTS];
    logic [NUM_CLIENTS-1:0] r_valid;
    t_entry                 r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_valid[i_req.rd_addr];
            end
        end
    end

    // never-written entries read as the reset value
    assign o_rd = r_rd_vld ? r_rd_data : '0;

endmodule

// ----- sv/pbc_core.sv -----
// Request sequencer: table read-modify-write, completion scan and global state.
module pbc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  pbc_pkg::t_in      i_req,
    input  pbc_pkg::t_cfg     i_cfg,
    input  logic              i_take,
    output logic              o_idle,
    output logic              o_done,
    output pbc_pkg::t_out     o_res,
    output pbc_pkg::t_mem_req o_mem,
    input  pbc_pkg::t_entry   i_rd
);
    import pbc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    t_in               r_req, n_req;
    t_out              r_res, n_res;
    logic [31:0]       r_cur, n_cur;
    logic [6:0]        r_count, n_count;
    logic [31:0]       r_seq, n_seq;
    logic              r_halt, n_halt;
    logic [SCAN_W-1:0] r_idx, n_idx;
    logic              r_all, n_all;

    logic    id_ok;
    logic    fin;
    logic    send;
    t_status status;

    assign id_ok = r_req.client_num < 16'(NUM_CLIENTS);

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_res   = r_res;
        n_cur   = r_cur;
        n_count = r_count;
        n_seq   = r_seq;
        n_halt  = r_halt;
        n_idx   = r_idx;
        n_all   = r_all;
        o_mem   = '0;
        fin     = 1'b0;
        send    = 1'b0;
        status  = ST_OK;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req         = i_req;
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = i_req.client_num[CLIENT_AW-1:0];
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                fin           = 1'b1;
                o_mem.wr_addr = r_req.client_num[CLIENT_AW-1:0];
                if (r_halt) begin
                    status = ST_HALTED;
                end else begin
                    case (r_req.opcode)
                        OP_REGISTER: begin
                            if (!id_ok) begin
                                status = ST_RANGE;
                            end else if (i_rd.registered) begin
                                status = ST_ALREADY_REG;
                            end else begin
                                o_mem.wr_en   = 1'b1;
                                o_mem.wr_data = '{registered: 1'b1, last_period: r_cur};
                                n_count       = r_count + 7'd1;
                                send          = n_count >= i_cfg.min_count;
                            end
                        end
                        OP_UNREGISTER: begin
                            if (!id_ok) begin
                                status = ST_RANGE;
                            end else if (!i_rd.registered) begin
                                status = ST_NOT_REG;
                            end else begin
                                o_mem.wr_en   = 1'b1;
                                o_mem.wr_data = '{registered: 1'b0,
                                                  last_period: i_rd.last_period};
                                n_count       = r_count - 7'd1;
                            end
                        end
                        OP_FINISHED: begin
                            if (r_req.period_id > signed'(r_cur)) begin
                                status = ST_AHEAD;
                            end else if (!id_ok) begin
                                status = ST_RANGE;
                            end else if (!i_rd.registered) begin
                                status = ST_NOT_REG;
                            end else if (r_req.period_id < signed'(i_rd.last_period)) begin
                                status = ST_STALE;
                            end else begin
                                o_mem.wr_en   = 1'b1;
                                o_mem.wr_data = '{registered: 1'b1,
                                                  last_period: r_req.period_id};
                                fin           = 1'b0;
                                n_idx         = '0;
                                n_all         = 1'b1;
                                n_state       = S_SCAN;
                            end
                        end
                        default: begin
                            status = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // read issued one cycle, checked the next
                if (r_idx < SCAN_W'(NUM_CLIENTS)) begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = r_idx[CLIENT_AW-1:0];
                    n_idx         = r_idx + SCAN_W'(1);
                end
                if (r_idx != '0 && i_rd.registered && i_rd.last_period != r_cur) begin
                    n_all = 1'b0;
                end
                if (r_idx == SCAN_W'(NUM_CLIENTS)) begin
                    fin  = 1'b1;
                    send = n_all;
                    if (n_all) begin
                        n_cur = r_cur + 32'd1;
                    end
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            if (!r_halt) begin
                if (send) begin
                    n_seq = r_seq + 32'd1;
                end
                if (i_cfg.halt_period != '0 && !n_cur[31] &&
                    n_cur[30:0] >= i_cfg.halt_period) begin
                    n_halt = 1'b1;
                end
            end
            n_res.status              = status;
            n_res.permission_sent     = send;
            n_res.permission_period   = send ? n_cur[30:0] : '0;
            n_res.permission_run_time = send ? i_cfg.barrier_run_time : '0;
            n_res.permission_sequence = send ? n_seq : '0;
            n_res.registered_count    = n_count;
            n_res.halted              = n_halt;
            n_state                   = S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_res <= n_res;
        r_idx <= n_idx;
        r_all <= n_all;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= 32'd1;
            r_count <= '0;
            r_seq   <= '0;
            r_halt  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_count <= n_count;
            r_seq   <= n_seq;
            r_halt  <= n_halt;
        end
    end

    assign o_idle = r_state == S_IDLE;
    assign o_done = r_state == S_DONE;
    assign o_res  = r_res;

endmodule

// ----- sv/period_barrier_controller_unit.sv -----
// Top level of the period barrier controller: ports, config registers, output register.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | in        | i_in_valid / o_in_ready   | i_in  (pbc_pkg::t_in)
//  out     | out       | o_out_valid / i_out_ready | o_out (pbc_pkg::t_out)
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Every request other than a valid finished request goes through the table read and
// evaluation; a valid finished request then scans all NUM_CLIENTS entries, one per cycle.
// A new request is taken while the previous result waits in the output register;
// the sequencer holds its result until that register frees up.
// Reset (i_rst_n low, synchronous) clears the valid bits of the client RAM at once.
module period_barrier_controller_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  pbc_pkg::t_in                     i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output pbc_pkg::t_out                    o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pbc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                      i_cfg_data
);
    import pbc_pkg::*;

    t_cfg     r_cfg;
    logic     r_out_valid;
    t_out     r_out;
    logic     core_idle;
    logic     core_done;
    logic     take;
    t_out     core_res;
    t_mem_req mem_req;
    t_entry   mem_rd;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = core_idle;
    assign take        = core_done && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_count        <= 7'd1;
            r_cfg.barrier_run_time <= '0;
            r_cfg.halt_period      <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_COUNT:   r_cfg.min_count        <= i_cfg_data[6:0];
                CFG_RUN_TIME:    r_cfg.barrier_run_time <= i_cfg_data;
                CFG_HALT_PERIOD: r_cfg.halt_period      <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    pbc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_in_valid && o_in_ready),
        .i_req   (i_in),
        .i_cfg   (r_cfg),
        .i_take  (take),
        .o_idle  (core_idle),
        .o_done  (core_done),
        .o_res   (core_res),
        .o_mem   (mem_req),
        .i_rd    (mem_rd)
    );

    pbc_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rd    (mem_rd)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.registered_count <= 7'(NUM_CLIENTS))
        else $error("registered count above table size");

    a_no_perm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.permission_sent) |->
            (o_out.permission_period == '0 && o_out.permission_run_time == '0
             && o_out.permission_sequence == '0))
        else $error("permission fields set without a permission");

    a_halt_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_HALTED) |-> o_out.halted)
        else $error("halted status without halt flag");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while another is in flight");

endmodule
